// ----- hdl/spn_block_encrypt_assert.svh -----
// Assertion macros for the SPN block encryption pipeline.
// Included by the top level; needs no package.
`ifndef SPN_BLOCK_ENCRYPT_ASSERT_SVH
`define SPN_BLOCK_ENCRYPT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked while out of reset.
`define SPN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spn_block_encrypt: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define SPN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spn_block_encrypt: next-cycle check failed");

`else

`define SPN_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SPN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/spn_pkg.sv -----
// Shared types, constants and round functions of the SPN block cipher.
// No dependencies; used by every module of the block.
package spn_pkg;

	localparam int BLOCK_BITS = 16;
	localparam int SBOX_BITS  = 4;
	localparam int NIBBLES    = BLOCK_BITS / SBOX_BITS;
	localparam int TABLE_BITS = 64;
	localparam int NUM_KEYS   = 4;
	localparam int ROUNDS_DEF = 4;
	localparam int CFG_IDX_BITS = 3;

	typedef logic [BLOCK_BITS-1:0] blk_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t CFG_SBOX      = 3'd0;
	localparam cfg_idx_t CFG_PERM      = 3'd1;
	localparam cfg_idx_t CFG_KEY0      = 3'd2;
	localparam cfg_idx_t CFG_KEY1      = 3'd3;
	localparam cfg_idx_t CFG_KEY2      = 3'd4;
	localparam cfg_idx_t CFG_KEY3      = 3'd5;
	localparam cfg_idx_t CFG_KEY_FINAL = 3'd6;

	// Everything the round stages need from the register file.
	typedef struct packed {
		logic [TABLE_BITS-1:0]              sbox;
		logic [TABLE_BITS-1:0]              perm;
		logic [NUM_KEYS-1:0][BLOCK_BITS-1:0] keys;
		blk_t                               key_final;
	} spn_cfg_t;

	// Pass every nibble through the S-box; entry k sits in bits 4k+3..4k.
	function automatic blk_t substitute(blk_t x, logic [TABLE_BITS-1:0] sbox);
		blk_t y;
		logic [SBOX_BITS-1:0] nib;
		y = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			nib = x[i*SBOX_BITS +: SBOX_BITS];
			y[i*SBOX_BITS +: SBOX_BITS] = sbox[{nib, 2'b00} +: SBOX_BITS];
		end
		return y;
	endfunction

	// Move input bit k to the position held in field k. Colliding bits OR
	// together and positions that nobody names stay zero.
	function automatic blk_t permute(blk_t x, logic [TABLE_BITS-1:0] perm);
		blk_t y;
		logic [3:0] pos;
		y = '0;
		for (int k = 0; k < BLOCK_BITS; k++) begin
			pos = perm[k*4 +: 4];
			y[pos] = y[pos] | x[k];
		end
		return y;
	endfunction

endpackage

// ----- hdl/spn_block_encrypt.sv -----
// spn_block_encrypt: 16-bit substitution-permutation network encryptor.
//
// Input channel plain_valid / plain_stall / plain_block: a beat is taken at a
// rising edge with plain_valid high and plain_stall low. Output channel
// cipher_valid / cipher_stall / cipher_block works the same way, with the
// downstream side driving cipher_stall.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data write register
// cfg_index (0 S-box, 1 permutation, 2..5 round keys, 6 final key). cfg_ready
// is always high. Write only while the pipeline is empty.
// Path: a block taken passes one input register, then one register per round,
// before it shows on cipher_block. Throughput: one block per cycle while
// cipher_stall is low, set by the one-round-per-stage pipeline; each stage holds
// a key XOR, the S-box lookup and the permutation (last stage: final key XOR).
// Stalls: each stage refills whenever it is empty or its successor moves, so
// bubbles close up; plain_stall rises only when every stage holds a block and
// cipher_stall is high. Nothing is dropped or duplicated.
// Reset (arst_n low): stage valids and configuration registers clear to zero.
// Depends on spn_pkg, spn_cfg_regs, spn_round and the assertion header.
`include "spn_block_encrypt_assert.svh"

module spn_block_encrypt
	import spn_pkg::*;
#(
	parameter int ROUNDS = ROUNDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  plain_valid,
	output logic                  plain_stall,
	input  blk_t                  plain_block,
	output logic                  cipher_valid,
	input  logic                  cipher_stall,
	output blk_t                  cipher_block,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [TABLE_BITS-1:0] cfg_data
);

	spn_cfg_t       cfg;
	logic           valid_s1;
	blk_t           blk_s1;
	logic [ROUNDS:0] stage_valid;
	blk_t           stage_blk [ROUNDS+1];
	logic [ROUNDS:0] take;

	spn_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register in front of the rounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take[0]) begin
			valid_s1 <= plain_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take[0] && plain_valid) begin
			blk_s1 <= plain_block;
		end
	end

	assign stage_valid[0] = valid_s1;
	assign stage_blk[0]   = blk_s1;

	// A stage takes a beat when it is empty or its own beat moves on.
	assign take[ROUNDS] = !stage_valid[ROUNDS] || !cipher_stall;

	generate
		for (genvar r = 0; r < ROUNDS; r++) begin : g_take
			assign take[r] = !stage_valid[r] || take[r+1];
		end

		// One stage per round; the last one adds the final key.
		for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
			spn_round #(
				.LAST (r == ROUNDS)
			) u_round (
				.clk      (clk),
				.arst_n   (arst_n),
				.take     (take[r]),
				.up_valid (stage_valid[r-1]),
				.up_blk   (stage_blk[r-1]),
				.key      (cfg.keys[r-1]),
				.cfg      (cfg),
				.valid_s1 (stage_valid[r]),
				.blk_s1   (stage_blk[r])
			);
		end
	endgenerate

	assign plain_stall  = !take[0];
	assign cipher_valid = stage_valid[ROUNDS];
	assign cipher_block = stage_blk[ROUNDS];

	// The input is held off only when the whole pipeline is full and blocked.
	`SPN_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, plain_stall, cipher_stall && (&stage_valid))
	// An accepted beat lands in the input register.
	`SPN_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, plain_valid && !plain_stall, valid_s1)
	// A held input register keeps its block.
	`SPN_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && plain_stall, valid_s1 && $stable(blk_s1))

endmodule

// ----- hdl/spn_cfg_regs.sv -----
// Configuration register file of the SPN cipher: S-box, permutation, keys.
// Depends on spn_pkg.
module spn_cfg_regs
	import spn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [TABLE_BITS-1:0] cfg_data,
	output spn_cfg_t              cfg
);

	spn_cfg_t cfg_q;

	// Writes are always taken; the user must write only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Decode the register index; an unknown index leaves everything alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SBOX:      cfg_q.sbox      <= cfg_data;
				CFG_PERM:      cfg_q.perm      <= cfg_data;
				CFG_KEY0:      cfg_q.keys[0]   <= cfg_data[BLOCK_BITS-1:0];
				CFG_KEY1:      cfg_q.keys[1]   <= cfg_data[BLOCK_BITS-1:0];
				CFG_KEY2:      cfg_q.keys[2]   <= cfg_data[BLOCK_BITS-1:0];
				CFG_KEY3:      cfg_q.keys[3]   <= cfg_data[BLOCK_BITS-1:0];
				CFG_KEY_FINAL: cfg_q.key_final <= cfg_data[BLOCK_BITS-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

endmodule

// ----- hdl/spn_round.sv -----
// One round of the SPN cipher as a single pipeline stage.
// Depends on spn_pkg for the substitution and permutation functions.
module spn_round
	import spn_pkg::*;
#(
	parameter bit LAST = 1'b0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  logic     up_valid,
	input  blk_t     up_blk,
	input  blk_t     key,
	input  spn_cfg_t cfg,
	output logic     valid_s1,
	output blk_t     blk_s1
);

	blk_t subbed;
	blk_t round_out;

	// Key mixing and substitution are common to every round.
	assign subbed = substitute(up_blk ^ key, cfg.sbox);

	// Inner rounds permute; the last round adds the whitening key instead.
	generate
		if (LAST) begin : g_last
			assign round_out = subbed ^ cfg.key_final;
		end else begin : g_inner
			assign round_out = permute(subbed, cfg.perm);
		end
	endgenerate

	// Stage valid moves whenever this stage can take a new beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= up_valid;
		end
	end

	// Payload loads only with a real beat.
	always_ff @(posedge clk) begin
		if (take && up_valid) begin
			blk_s1 <= round_out;
		end
	end

endmodule

// ----- tb/sv/spn_block_encrypt_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for spn_block_encrypt: drives plaintext beats, predicts each
// ciphertext from a local model of the rounds and compares it with every output beat.
// Depends on spn_pkg and the spn_block_encrypt RTL only.
module spn_block_encrypt_tb
	import spn_pkg::*;
;

	localparam int ROUNDS = ROUNDS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 20;
	localparam logic [TABLE_BITS-1:0] IDENTITY_TABLE = 64'hFEDC_BA98_7654_3210;
	// Pairs of input bits land on the same even output position.
	localparam logic [TABLE_BITS-1:0] PAIRED_PERM = 64'hEECC_AA88_6644_2200;
	// Index that no register answers to; writes to it must be ignored.
	localparam cfg_idx_t CFG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic plain_valid = 1'b0;
	logic plain_stall;
	blk_t plain_block = '0;
	logic cipher_valid;
	logic cipher_stall = 1'b0;
	blk_t cipher_block;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = CFG_SBOX;
	logic [TABLE_BITS-1:0] cfg_data = '0;

	// Local copy of the register file used for prediction.
	logic [TABLE_BITS-1:0] sbox_reg = '0;
	logic [TABLE_BITS-1:0] perm_reg = '0;
	blk_t key_reg [NUM_KEYS] = '{default: '0};
	blk_t key_fin = '0;

	blk_t expected_cipher [$];
	blk_t cipher_want;
	int err_count = 0;
	int blocks_sent = 0;
	int blocks_checked = 0;
	int settings_used = 0;
	int input_stall_cycles = 0;
	int cycles = 0;
	int stall_left = 0;
	int hold_req = 0;
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;

	spn_block_encrypt u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.plain_valid  (plain_valid),
		.plain_stall  (plain_stall),
		.plain_block  (plain_block),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher_block (cipher_block),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Look every nibble up in the current S-box.
	function automatic blk_t sbox_nibbles(blk_t x);
		blk_t y;
		logic [3:0] nib;
		y = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			nib = x[4*i +: 4];
			y = y | (blk_t'((sbox_reg >> (4 * nib)) & 64'hF) << (4 * i));
		end
		return y;
	endfunction

	// Scatter each set bit to its target; colliding bits merge as an OR.
	function automatic blk_t scatter_bits(blk_t x);
		blk_t y;
		y = '0;
		for (int k = 0; k < BLOCK_BITS; k++) begin
			if (x[k]) begin
				y[perm_reg[4*k +: 4]] = 1'b1;
			end
		end
		return y;
	endfunction

	// Full encryption of one block under the current settings.
	function automatic blk_t predict_cipher(blk_t plain);
		blk_t x;
		x = plain;
		for (int r = 0; r < ROUNDS - 1; r++) begin
			x = scatter_bits(sbox_nibbles(x ^ key_reg[r]));
		end
		return sbox_nibbles(x ^ key_reg[ROUNDS-1]) ^ key_fin;
	endfunction

	// Random 16-entry permutation of the nibble values 0..15.
	function automatic logic [TABLE_BITS-1:0] shuffled_table();
		logic [3:0] slot [16];
		logic [3:0] t;
		logic [TABLE_BITS-1:0] tbl;
		int j;
		for (int i = 0; i < 16; i++) begin
			slot[i] = 4'(i);
		end
		for (int i = 15; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = slot[i];
			slot[i] = slot[j];
			slot[j] = t;
		end
		for (int i = 0; i < 16; i++) begin
			tbl[4*i +: 4] = slot[i];
		end
		return tbl;
	endfunction

	function automatic logic [TABLE_BITS-1:0] pick_table();
		case ($urandom_range(0, 5))
			0: return IDENTITY_TABLE;
			1: return '0;
			2: return '1;
			3: return {$urandom, $urandom};
			default: return shuffled_table();
		endcase
	endfunction

	function automatic blk_t pick_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return blk_t'($urandom);
		endcase
	endfunction

	function automatic blk_t pick_block();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return blk_t'(1) << $urandom_range(0, BLOCK_BITS - 1);
			default: return blk_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		err_count++;
	endtask

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles++;
		if (plain_valid && plain_stall) begin
			input_stall_cycles++;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycles,
				expected_cipher.size());
			$display("spn_block_encrypt_tb NOT OK");
			$finish;
		end
	end

	// Output side: random stall bursts, plus a long hold when a test asks for one.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16);
		end
		cipher_stall <= (stall_left > 0);
	end

	// Compare every accepted output beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && cipher_valid && !cipher_stall) begin
			if (expected_cipher.size() == 0) begin
				report_mismatch($sformatf("unexpected beat 0x%04h", cipher_block));
			end else begin
				cipher_want = expected_cipher.pop_front();
				if (cipher_block !== cipher_want) begin
					report_mismatch($sformatf("cipher_block 0x%04h, expected 0x%04h",
						cipher_block, cipher_want));
				end
				blocks_checked++;
			end
		end
	end

	// Offer one plaintext beat, with an optional random gap first, and
	// record its expected ciphertext once it is taken.
	task automatic send_block(input blk_t value);
		int n;
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 7) == 0) begin
			plain_valid <= 1'b0;
			n = $urandom_range(1, 16);
			repeat (n) @(negedge clk);
		end
		plain_valid <= 1'b1;
		plain_block <= value;
		@(posedge clk);
		while (plain_stall) @(posedge clk);
		expected_cipher.insert(expected_cipher.size(), predict_cipher(value));
		blocks_sent++;
	endtask

	// Stop offering and wait until every expected beat has come out.
	task automatic wait_drain();
		@(negedge clk);
		plain_valid <= 1'b0;
		while (expected_cipher.size() != 0) @(posedge clk);
		repeat (ROUNDS + 2) @(posedge clk);
	endtask

	// Write one register and mirror it into the local model.
	task automatic write_reg(input cfg_idx_t idx, input logic [TABLE_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_SBOX: sbox_reg = data;
			CFG_PERM: perm_reg = data;
			CFG_KEY0: key_reg[0] = data[BLOCK_BITS-1:0];
			CFG_KEY1: key_reg[1] = data[BLOCK_BITS-1:0];
			CFG_KEY2: key_reg[2] = data[BLOCK_BITS-1:0];
			CFG_KEY3: key_reg[3] = data[BLOCK_BITS-1:0];
			CFG_KEY_FINAL: key_fin = data[BLOCK_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [TABLE_BITS-1:0] sbox, input logic [TABLE_BITS-1:0] perm,
			input blk_t k0, input blk_t k1, input blk_t k2, input blk_t k3, input blk_t kf);
		write_reg(CFG_SBOX, sbox);
		write_reg(CFG_PERM, perm);
		write_reg(CFG_KEY0, {48'h0, k0});
		write_reg(CFG_KEY1, {48'h0, k1});
		write_reg(CFG_KEY2, {48'h0, k2});
		write_reg(CFG_KEY3, {48'h0, k3});
		write_reg(CFG_KEY_FINAL, {48'h0, kf});
		settings_used++;
	endtask

	// Reset values: every S-box entry is zero, so every block encrypts to zero.
	task automatic test_reset_settings();
		send_block('0);
		send_block('1);
		send_block(16'h0001);
		send_block(16'h8000);
		wait_drain();
	endtask

	// Directed settings: pass-through, all ones, colliding permutation with
	// an ignored write, and upper bits of the key data set.
	task automatic test_directed();
		write_all(IDENTITY_TABLE, IDENTITY_TABLE, '0, '0, '0, '0, '0);
		send_block('0);
		send_block('1);
		send_block(16'hA5A5);
		send_block(16'h5A5A);
		send_block(16'h0010);
		wait_drain();
		write_all('1, '1, '1, '1, '1, '1, '1);
		send_block('0);
		send_block('1);
		send_block(16'h1234);
		wait_drain();
		write_all(shuffled_table(), PAIRED_PERM, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3, 16'h8001);
		write_reg(CFG_UNUSED, '1);
		send_block('0);
		send_block('1);
		send_block(16'hAAAA);
		send_block(16'h5555);
		send_block(16'h0001);
		send_block(16'h8000);
		wait_drain();
		// Only the low 16 bits of a key write count.
		write_reg(CFG_KEY_FINAL, 64'hFFFF_FFFF_FFFF_0000);
		write_reg(CFG_KEY0, 64'h0123_4567_89AB_FFFF);
		send_block(16'h0F0F);
		send_block(16'hF0F0);
		wait_drain();
	endtask

	// Several random settings, each followed by a run of random blocks.
	task automatic test_random_settings(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			write_all(pick_table(), pick_table(), pick_key(), pick_key(), pick_key(),
				pick_key(), pick_key());
			if ($urandom_range(0, 1) == 0) begin
				write_reg(CFG_UNUSED, {$urandom, $urandom});
			end
			for (int i = 0; i < per_phase; i++) begin
				send_block(pick_block());
			end
			wait_drain();
		end
	endtask

	// Long output hold while the input keeps offering, so the pipeline fills and stalls;
	// then drain pauses, and two further runs with random input gaps, each drained.
	task automatic test_backpressure();
		send_gaps = 1'b0;
		hold_req = 300;
		for (int i = 0; i < 40; i++) begin
			send_block(pick_block());
		end
		wait_drain();
		send_gaps = 1'b1;
		for (int i = 0; i < 20; i++) begin
			send_block(pick_block());
		end
		wait_drain();
		for (int i = 0; i < 20; i++) begin
			send_block(pick_block());
		end
		wait_drain();
	endtask

	// Closing stretch at full rate with neither side idling.
	task automatic test_full_rate(input int count);
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		write_all(shuffled_table(), shuffled_table(), pick_key(), pick_key(), pick_key(),
			pick_key(), pick_key());
		for (int i = 0; i < count; i++) begin
			send_block(pick_block());
		end
		wait_drain();
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_reset_settings();
		test_directed();
		test_random_settings(6, 150);
		test_backpressure();
		test_full_rate(300);
		$display("Encrypted %0d blocks under %0d register settings, %0d beats checked.",
			blocks_sent, settings_used, blocks_checked);
		$display("Included a %0d-cycle input stall from a long output hold and drain pauses.",
			input_stall_cycles);
		if (err_count == 0 && expected_cipher.size() == 0) begin
			$display("spn_block_encrypt_tb OK");
		end else begin
			$display("%0d mismatches, %0d beats never seen", err_count, expected_cipher.size());
			$display("spn_block_encrypt_tb NOT OK");
		end
		$finish;
	end

endmodule
